// File: hw/rtl/kmce_pkg.sv
package kmce_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_NUM_CLUSTERS = 2'd0,
    REG_NUM_DIMS     = 2'd1,
    REG_ERR_THR      = 2'd2
  } reg_idx_e;

  typedef enum logic [12:0] {
    ST_IDLE      = 13'b0000000000001,
    ST_LBL_SEND  = 13'b0000000000010,
    ST_ERR_SEND  = 13'b0000000000100,
    ST_SEED_STEP = 13'b0000000001000,
    ST_SEED_ACC  = 13'b0000000010000,
    ST_SEED_DIV  = 13'b0000000100000,
    ST_ASN       = 13'b0000001000000,
    ST_UPD       = 13'b0000010000000,
    ST_UPD_DIV   = 13'b0000100000000,
    ST_CHECK     = 13'b0001000000000,
    ST_OUT_DIV   = 13'b0010000000000,
    ST_OUT_SEND  = 13'b0100000000000,
    ST_SPARE     = 13'b1000000000000
  } state_e;

  localparam int unsigned CFG_AW             = 4;
  localparam int unsigned ITER_LIMIT         = 20;
  localparam int unsigned MIN_MEMBERS        = 2;
  localparam int unsigned PERCENT_SCALE      = 100;
  localparam int unsigned POINTS_PER_CLUSTER = 4;
  localparam logic [3:0]  NC_RESET           = 4'd3;
  localparam logic [2:0]  ND_RESET           = 3'd3;
  localparam logic [7:0]  THR_RESET          = 8'd2;

endpackage

// File: hw/rtl/kmce_div.sv
module kmce_div #(
  parameter int unsigned DW = 24,
  parameter int unsigned VW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] a_i,
  input  logic [VW-1:0] b_i,
  output logic          done_o,
  output logic [DW-1:0] q_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] b_q, b_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [VW:0]   trial;
  logic          ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial  = {rem_q, quo_q[DW-1]};
    ge     = trial >= {1'b0, b_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = a_i;
      rem_d  = '0;
      b_d    = b_i;
      cnt_d  = CW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DW-2:0], ge};
      rem_d = ge ? VW'(trial - {1'b0, b_q}) : VW'(trial);
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign q_o    = quo_q;

endmodule

// File: hw/rtl/kmce_lane.sv
module kmce_lane #(
  parameter int unsigned MAX_DIMS = 4,
  parameter int unsigned SW       = 18,
  parameter int unsigned PCW      = 11,
  parameter int unsigned DISTW    = 19,
  parameter int unsigned NDW      = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [MAX_DIMS-1:0][7:0]     center_i,
  input  logic [MAX_DIMS-1:0][7:0]     point_i,
  input  logic [NDW-1:0]               nd_i,
  input  logic                         active_i,
  input  logic                         clr_i,
  input  logic                         acc_en_i,
  input  logic [MAX_DIMS-1:0][7:0]     acc_point_i,
  output logic [DISTW-1:0]             dist_o,
  output logic [MAX_DIMS-1:0][SW-1:0]  sum_o,
  output logic [PCW-1:0]               cnt_o
);

  logic [MAX_DIMS-1:0][15:0]   sq_q, sq_d;
  logic [DISTW-1:0]            dist_q, dist_d;
  logic [MAX_DIMS-1:0][SW-1:0] sum_q, sum_d;
  logic [PCW-1:0]              cnt_q, cnt_d;
  logic [7:0]                  diff;

  always_comb begin
    diff = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      diff    = (point_i[i] > center_i[i]) ? point_i[i] - center_i[i]
                                           : center_i[i] - point_i[i];
      sq_d[i] = (NDW'(i) < nd_i) ? diff * diff : 16'd0;
    end
    // inactive lanes never win the merge
    dist_d = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      dist_d = dist_d + DISTW'(sq_q[i]);
    end
    if (!active_i) dist_d = '1;
  end

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (clr_i) begin
      sum_d = '0;
      cnt_d = '0;
    end else if (acc_en_i) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        sum_d[i] = sum_q[i] + SW'(acc_point_i[i]);
      end
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    dist_q <= dist_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  assign dist_o = dist_q;
  assign sum_o  = sum_q;
  assign cnt_o  = cnt_q;

endmodule

// File: hw/rtl/kmce_merge.sv
module kmce_merge #(
  parameter int unsigned MAX_CLUSTERS = 8,
  parameter int unsigned DISTW        = 19,
  parameter int unsigned KW           = 3
) (
  input  logic                                clk_i,
  input  logic [MAX_CLUSTERS-1:0][DISTW-1:0]  dist_i,
  output logic [KW-1:0]                       pick_o
);

  localparam int unsigned NP = 1 << $clog2(MAX_CLUSTERS);

  logic [DISTW-1:0] node_d [2*NP-1];
  logic [KW-1:0]    node_k [2*NP-1];
  logic [KW-1:0]    pick_q;

  // min tree, left subtree holds lower indexes so ties keep the first
  always_comb begin
    for (int k = 0; k < NP; k++) begin
      node_d[NP-1+k] = (k < MAX_CLUSTERS) ? dist_i[k] : '1;
      node_k[NP-1+k] = KW'(k);
    end
    for (int i = NP - 2; i >= 0; i--) begin
      if (node_d[2*i+1] <= node_d[2*i+2]) begin
        node_d[i] = node_d[2*i+1];
        node_k[i] = node_k[2*i+1];
      end else begin
        node_d[i] = node_d[2*i+2];
        node_k[i] = node_k[2*i+2];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q <= node_k[0];
  end

  assign pick_o = pick_q;

endmodule

// File: hw/rtl/kmeans_clustering_engine.sv
// load and clear: one item per cycle; label read: result sent from ST_LBL_SEND
//   once the output slot is free; run: seeding (a step divide, then per cluster a
//   sum and a divide per dimension), then per iteration an assignment pass (one
//   point per cycle through the lanes), update divides in the shared divider and a
//   check state, then one result per cluster while the output is not stalled
// reset clears control state, point count, centers and lane sums; the point and
//   label memories are not cleared
module kmeans_clustering_engine #(
  parameter int unsigned MAX_POINTS   = 1024,
  parameter int unsigned MAX_DIMS     = 4,
  parameter int unsigned MAX_CLUSTERS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kmce_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  action_i,
  input  logic [7:0]                  coord_0_i,
  input  logic [7:0]                  coord_1_i,
  input  logic [7:0]                  coord_2_i,
  input  logic [7:0]                  coord_3_i,
  input  logic [9:0]                  point_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        kind_o,
  output logic                        status_o,
  output logic [2:0]                  cluster_index_o,
  output logic [6:0]                  percent_o,
  output logic [7:0]                  center_0_o,
  output logic [7:0]                  center_1_o,
  output logic [7:0]                  center_2_o,
  output logic [7:0]                  center_3_o,
  output logic [2:0]                  label_o,
  output logic                        last_o
);

  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned PCW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned KW    = $clog2(MAX_CLUSTERS);
  localparam int unsigned NCW   = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned DIW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned NDW   = $clog2(MAX_DIMS + 1);
  localparam int unsigned SW    = 8 + AW;
  localparam int unsigned DW    = (SW > PCW + 7) ? SW : PCW + 7;
  localparam int unsigned DISTW = 17 + $clog2(MAX_DIMS);
  localparam int unsigned MVW   = $clog2(MAX_CLUSTERS * MAX_DIMS * 255 + 1);
  localparam int unsigned DPAD  = (MAX_DIMS > 4) ? MAX_DIMS : 4;

  typedef logic [MAX_DIMS-1:0][7:0] point_t;

  // configuration
  logic [3:0] cfg_nc_q;
  logic [2:0] cfg_nd_q;
  logic [7:0] cfg_thr_q;
  logic       cfg_we;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_nc_q  <= kmce_pkg::NC_RESET;
      cfg_nd_q  <= kmce_pkg::ND_RESET;
      cfg_thr_q <= kmce_pkg::THR_RESET;
    end else if (cfg_we && paddr[1:0] == 2'd0) begin
      unique case (kmce_pkg::reg_idx_e'(paddr[3:2]))
        kmce_pkg::REG_NUM_CLUSTERS: cfg_nc_q  <= pwdata[3:0];
        kmce_pkg::REG_NUM_DIMS:     cfg_nd_q  <= pwdata[2:0];
        kmce_pkg::REG_ERR_THR:      cfg_thr_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'd0) begin
      unique case (kmce_pkg::reg_idx_e'(paddr[3:2]))
        kmce_pkg::REG_NUM_CLUSTERS: prdata = 32'(cfg_nc_q);
        kmce_pkg::REG_NUM_DIMS:     prdata = 32'(cfg_nd_q);
        kmce_pkg::REG_ERR_THR:      prdata = 32'(cfg_thr_q);
        default:                    prdata = '0;
      endcase
    end
  end

  // control and datapath registers
  kmce_pkg::state_e state_q, state_d;
  logic [NCW-1:0]   nc_q, nc_d;
  logic [NDW-1:0]   nd_q, nd_d;
  logic [MVW-1:0]   limit_q, limit_d;
  logic [MVW-1:0]   moved_q, moved_d;
  logic [PCW-1:0]   pc_q, pc_d;
  logic [PCW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PCW-1:0]   hi_q, hi_d;
  logic [PCW-1:0]   lo_q, lo_d;
  logic [PCW-1:0]   step_q, step_d;
  logic [KW-1:0]    k_q, k_d;
  logic [DIW-1:0]   d_q, d_d;
  logic [4:0]       iter_q, iter_d;
  logic             oob_q, oob_d;
  logic [6:0]       pct_q, pct_d;
  logic [MAX_DIMS-1:0][SW-1:0] acc_q, acc_d;
  logic [MAX_CLUSTERS-1:0][MAX_DIMS-1:0][7:0] center_q, center_d;

  logic             out_valid_q, out_valid_d;
  logic             kind_q, kind_d;
  logic             status_q, status_d;
  logic [2:0]       cidx_q, cidx_d;
  logic [6:0]       percent_q, percent_d;
  logic [3:0][7:0]  oc_q, oc_d;
  logic [2:0]       label_q, label_d;
  logic             last_q, last_d;

  // memories and assignment pipeline
  point_t         point_mem [MAX_POINTS];
  logic [KW-1:0]  label_mem [MAX_POINTS];
  point_t         point_rd_q;
  logic [KW-1:0]  label_rd_q;
  point_t         pd1_q, pd2_q, pd3_q;
  logic [AW-1:0]  idx0_q, idx1_q, idx2_q, idx3_q;
  logic [3:0]     vp_q;

  logic                      in_fire;
  logic                      slot_free;
  logic                      issue;
  logic                      lane_clr;
  logic                      div_start;
  logic [DW-1:0]             div_a;
  logic [PCW-1:0]            div_b;
  logic                      div_done;
  logic [DW-1:0]             div_q;
  logic [KW-1:0]             pick;
  logic [MAX_CLUSTERS-1:0][DISTW-1:0]         lane_dist;
  logic [MAX_CLUSTERS-1:0][MAX_DIMS-1:0][SW-1:0] lane_sum;
  logic [MAX_CLUSTERS-1:0][PCW-1:0]          lane_cnt;
  logic [DPAD-1:0][7:0]      coord_pad;
  logic [DPAD-1:0][7:0]      ctr_pad;
  point_t                    load_word;
  logic                      load_we;
  logic [NCW-1:0]            nc_cl;
  logic [NDW-1:0]            nd_cl;
  logic                      last_k;
  logic                      last_dim;
  logic [DIW-1:0]            d_nx;
  logic [KW-1:0]             k_nx;
  logic [7:0]                old_c;
  logic [7:0]                new_c;
  logic [PCW-1:0]            lo_n;
  logic [PCW-1:0]            ct;

  assign in_ready_o = (state_q == kmce_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign issue      = (state_q == kmce_pkg::ST_ASN || state_q == kmce_pkg::ST_SEED_ACC)
                      && (rd_ptr_q < hi_q);

  always_comb begin
    coord_pad    = '0;
    coord_pad[0] = coord_0_i;
    coord_pad[1] = coord_1_i;
    coord_pad[2] = coord_2_i;
    coord_pad[3] = coord_3_i;
    for (int i = 0; i < MAX_DIMS; i++) load_word[i] = coord_pad[i];
  end

  assign load_we = in_fire && (kmce_pkg::action_e'(action_i) == kmce_pkg::ACT_LOAD)
                   && (pc_q < PCW'(MAX_POINTS));

  always_comb begin
    if (cfg_nc_q == 4'd0) nc_cl = NCW'(1);
    else if (32'(cfg_nc_q) > 32'(MAX_CLUSTERS)) nc_cl = NCW'(MAX_CLUSTERS);
    else nc_cl = NCW'(cfg_nc_q);
    if (cfg_nd_q == 3'd0) nd_cl = NDW'(1);
    else if (32'(cfg_nd_q) > 32'(MAX_DIMS)) nd_cl = NDW'(MAX_DIMS);
    else nd_cl = NDW'(cfg_nd_q);
  end

  always_ff @(posedge clk_i) begin
    if (load_we) point_mem[pc_q[AW-1:0]] <= load_word;
    point_rd_q <= point_mem[rd_ptr_q[AW-1:0]];
    if (vp_q[3] && state_q == kmce_pkg::ST_ASN) label_mem[idx3_q] <= pick;
    if (in_fire) label_rd_q <= label_mem[AW'(point_index_i)];
    pd1_q  <= point_rd_q;
    pd2_q  <= pd1_q;
    pd3_q  <= pd2_q;
    idx0_q <= rd_ptr_q[AW-1:0];
    idx1_q <= idx0_q;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vp_q <= '0;
    else         vp_q <= {vp_q[2:0], issue};
  end

  // lanes and merge
  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_lane
    kmce_lane #(
      .MAX_DIMS(MAX_DIMS), .SW(SW), .PCW(PCW), .DISTW(DISTW), .NDW(NDW)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .center_i   (center_q[g]),
      .point_i    (point_rd_q),
      .nd_i       (nd_q),
      .active_i   (NCW'(g) < nc_q),
      .clr_i      (lane_clr),
      .acc_en_i   (vp_q[3] && state_q == kmce_pkg::ST_ASN && pick == KW'(g)),
      .acc_point_i(pd3_q),
      .dist_o     (lane_dist[g]),
      .sum_o      (lane_sum[g]),
      .cnt_o      (lane_cnt[g])
    );
  end

  kmce_merge #(.MAX_CLUSTERS(MAX_CLUSTERS), .DISTW(DISTW), .KW(KW)) u_merge (
    .clk_i (clk_i),
    .dist_i(lane_dist),
    .pick_o(pick)
  );

  kmce_div #(.DW(DW), .VW(PCW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .a_i    (div_a),
    .b_i    (div_b),
    .done_o (div_done),
    .q_o    (div_q)
  );

  always_comb begin
    last_k   = (NCW'(k_q) + NCW'(1)) == nc_q;
    last_dim = (NDW'(d_q) + NDW'(1)) == nd_q;
    d_nx     = d_q + 1'b1;
    k_nx     = k_q + 1'b1;
    old_c    = center_q[k_q][d_q];
    ct       = lane_cnt[k_q];
    lo_n     = lo_q + step_q;
    ctr_pad  = '0;
    for (int i = 0; i < MAX_DIMS; i++) ctr_pad[i] = center_q[k_q][i];
  end

  always_comb begin
    state_d     = state_q;
    nc_d        = nc_q;
    nd_d        = nd_q;
    limit_d     = limit_q;
    moved_d     = moved_q;
    pc_d        = pc_q;
    rd_ptr_d    = rd_ptr_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    step_d      = step_q;
    k_d         = k_q;
    d_d         = d_q;
    iter_d      = iter_q;
    oob_d       = oob_q;
    pct_d       = pct_q;
    acc_d       = acc_q;
    center_d    = center_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    status_d    = status_q;
    cidx_d      = cidx_q;
    percent_d   = percent_q;
    oc_d        = oc_q;
    label_d     = label_q;
    last_d      = last_q;
    lane_clr    = 1'b0;
    div_start   = 1'b0;
    div_a       = '0;
    div_b       = '0;
    new_c       = old_c;

    if (issue) rd_ptr_d = rd_ptr_q + 1'b1;

    unique case (state_q) inside
      kmce_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (kmce_pkg::action_e'(action_i))
            kmce_pkg::ACT_LOAD:  if (load_we) pc_d = pc_q + 1'b1;
            kmce_pkg::ACT_CLEAR: pc_d = '0;
            kmce_pkg::ACT_READ: begin
              oob_d   = 32'(point_index_i) >= 32'(MAX_POINTS);
              state_d = kmce_pkg::ST_LBL_SEND;
            end
            default: begin
              nc_d    = nc_cl;
              nd_d    = nd_cl;
              limit_d = MVW'(32'(nc_cl) * 32'(nd_cl) * 32'(cfg_thr_q));
              if (32'(pc_q) < kmce_pkg::POINTS_PER_CLUSTER * 32'(nc_cl)) begin
                state_d = kmce_pkg::ST_ERR_SEND;
              end else begin
                div_start = 1'b1;
                div_a     = DW'(pc_q);
                div_b     = PCW'(nc_cl);
                k_d       = '0;
                lo_d      = '0;
                iter_d    = '0;
                state_d   = kmce_pkg::ST_SEED_STEP;
              end
            end
          endcase
        end
      end

      kmce_pkg::ST_LBL_SEND: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          kind_d      = 1'b1;
          status_d    = 1'b0;
          cidx_d      = '0;
          percent_d   = '0;
          oc_d        = '0;
          label_d     = oob_q ? 3'd0 : 3'(label_rd_q);
          last_d      = 1'b1;
          state_d     = kmce_pkg::ST_IDLE;
        end
      end

      kmce_pkg::ST_ERR_SEND: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          kind_d      = 1'b0;
          status_d    = 1'b1;
          cidx_d      = '0;
          percent_d   = '0;
          oc_d        = '0;
          label_d     = '0;
          last_d      = 1'b1;
          state_d     = kmce_pkg::ST_IDLE;
        end
      end

      kmce_pkg::ST_SEED_STEP: begin
        if (div_done) begin
          step_d   = PCW'(div_q);
          hi_d     = (nc_q == NCW'(1)) ? pc_q : PCW'(div_q);
          rd_ptr_d = '0;
          acc_d    = '0;
          state_d  = kmce_pkg::ST_SEED_ACC;
        end
      end

      kmce_pkg::ST_SEED_ACC: begin
        if (vp_q[0]) begin
          for (int i = 0; i < MAX_DIMS; i++) acc_d[i] = acc_q[i] + SW'(point_rd_q[i]);
        end
        if (rd_ptr_q == hi_q && !vp_q[0]) begin
          div_start = 1'b1;
          div_a     = DW'(acc_q[0]);
          div_b     = hi_q - lo_q;
          d_d       = '0;
          state_d   = kmce_pkg::ST_SEED_DIV;
        end
      end

      kmce_pkg::ST_SEED_DIV: begin
        if (div_done) begin
          center_d[k_q][d_q] = div_q[7:0];
          if (!last_dim) begin
            d_d       = d_nx;
            div_start = 1'b1;
            div_a     = DW'(acc_q[d_nx]);
            div_b     = hi_q - lo_q;
          end else if (last_k) begin
            rd_ptr_d = '0;
            hi_d     = pc_q;
            lane_clr = 1'b1;
            state_d  = kmce_pkg::ST_ASN;
          end else begin
            k_d      = k_nx;
            lo_d     = lo_n;
            hi_d     = ((NCW'(k_nx) + NCW'(1)) == nc_q) ? pc_q : lo_n + step_q;
            rd_ptr_d = lo_n;
            acc_d    = '0;
            state_d  = kmce_pkg::ST_SEED_ACC;
          end
        end
      end

      kmce_pkg::ST_ASN: begin
        if (rd_ptr_q == hi_q && vp_q == 4'd0) begin
          k_d     = '0;
          d_d     = '0;
          moved_d = '0;
          state_d = kmce_pkg::ST_UPD;
        end
      end

      kmce_pkg::ST_UPD, kmce_pkg::ST_UPD_DIV: begin
        if (state_q == kmce_pkg::ST_UPD && 32'(ct) > kmce_pkg::MIN_MEMBERS) begin
          div_start = 1'b1;
          div_a     = DW'(lane_sum[k_q][d_q]);
          div_b     = ct;
          state_d   = kmce_pkg::ST_UPD_DIV;
        end else if (state_q == kmce_pkg::ST_UPD || div_done) begin
          if (state_q == kmce_pkg::ST_UPD_DIV) new_c = div_q[7:0];
          moved_d = moved_q + MVW'((old_c > new_c) ? old_c - new_c : new_c - old_c);
          center_d[k_q][d_q] = new_c;
          state_d = kmce_pkg::ST_UPD;
          if (last_dim) begin
            d_d = '0;
            if (last_k) state_d = kmce_pkg::ST_CHECK;
            else        k_d     = k_nx;
          end else begin
            d_d = d_nx;
          end
        end
      end

      kmce_pkg::ST_CHECK: begin
        iter_d = iter_q + 1'b1;
        if (32'(iter_q) > kmce_pkg::ITER_LIMIT || moved_q < limit_q) begin
          k_d       = '0;
          div_start = 1'b1;
          div_a     = DW'(lane_cnt[0]) * DW'(kmce_pkg::PERCENT_SCALE);
          div_b     = pc_q;
          state_d   = kmce_pkg::ST_OUT_DIV;
        end else begin
          rd_ptr_d = '0;
          hi_d     = pc_q;
          lane_clr = 1'b1;
          state_d  = kmce_pkg::ST_ASN;
        end
      end

      kmce_pkg::ST_OUT_DIV: begin
        if (div_done) begin
          pct_d   = div_q[6:0];
          state_d = kmce_pkg::ST_OUT_SEND;
        end
      end

      kmce_pkg::ST_OUT_SEND: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          kind_d      = 1'b0;
          status_d    = 1'b0;
          cidx_d      = 3'(k_q);
          percent_d   = pct_q;
          for (int i = 0; i < 4; i++) oc_d[i] = (NDW'(i) < nd_q) ? ctr_pad[i] : 8'd0;
          label_d     = '0;
          last_d      = last_k;
          if (last_k) begin
            state_d = kmce_pkg::ST_IDLE;
          end else begin
            k_d       = k_nx;
            div_start = 1'b1;
            div_a     = DW'(lane_cnt[k_nx]) * DW'(kmce_pkg::PERCENT_SCALE);
            div_b     = pc_q;
            state_d   = kmce_pkg::ST_OUT_DIV;
          end
        end
      end

      default: state_d = kmce_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kmce_pkg::ST_IDLE;
      pc_q        <= '0;
      rd_ptr_q    <= '0;
      hi_q        <= '0;
      k_q         <= '0;
      d_q         <= '0;
      iter_q      <= '0;
      center_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      rd_ptr_q    <= rd_ptr_d;
      hi_q        <= hi_d;
      k_q         <= k_d;
      d_q         <= d_d;
      iter_q      <= iter_d;
      center_q    <= center_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nc_q      <= nc_d;
    nd_q      <= nd_d;
    limit_q   <= limit_d;
    moved_q   <= moved_d;
    lo_q      <= lo_d;
    step_q    <= step_d;
    oob_q     <= oob_d;
    pct_q     <= pct_d;
    acc_q     <= acc_d;
    kind_q    <= kind_d;
    status_q  <= status_d;
    cidx_q    <= cidx_d;
    percent_q <= percent_d;
    oc_q      <= oc_d;
    label_q   <= label_d;
    last_q    <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign status_o        = status_q;
  assign cluster_index_o = cidx_q;
  assign percent_o       = percent_q;
  assign center_0_o      = oc_q[0];
  assign center_1_o      = oc_q[1];
  assign center_2_o      = oc_q[2];
  assign center_3_o      = oc_q[3];
  assign label_o         = label_q;
  assign last_o          = last_q;

endmodule

// File: bench/tb.sv
module tb;

  localparam int NPTS = 1024;

  typedef struct packed {
    logic       kind;
    logic       status;
    logic [2:0] cluster_index;
    logic [6:0] percent;
    logic [7:0] center_0;
    logic [7:0] center_1;
    logic [7:0] center_2;
    logic [7:0] center_3;
    logic [2:0] label;
    logic       last;
  } result_t;

  typedef struct packed {
    kmce_pkg::action_e act;
    logic [7:0]        c0;
    logic [7:0]        c1;
    logic [7:0]        c2;
    logic [7:0]        c3;
    logic [9:0]        idx;
  } item_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [kmce_pkg::CFG_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_ready_o;
  logic [1:0] action_i;
  logic [7:0] coord_0_i, coord_1_i, coord_2_i, coord_3_i;
  logic [9:0] point_index_i;
  logic out_valid_o, out_ready_i;
  logic kind_o, status_o, last_o;
  logic [2:0] cluster_index_o, label_o;
  logic [6:0] percent_o;
  logic [7:0] center_0_o, center_1_o, center_2_o, center_3_o;

  kmeans_clustering_engine dut (.*);

  // predictor state
  logic [7:0]  pts [NPTS][4];
  int unsigned npts;
  logic [2:0]  lbl [NPTS];
  bit          lbl_ok [NPTS];
  int unsigned ctr [8][4];
  int unsigned cfg_nc, cfg_nd, cfg_thr;

  result_t expected_results[$];
  int errors;
  int send_idle, recv_idle;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int unsigned adiff(int unsigned a, int unsigned b);
    return a > b ? a - b : b - a;
  endfunction

  // lloyd iteration, same order of operations as the hardware contract
  task automatic cluster_points();
    int unsigned nc, nd, step, lo, hi, acc, lim, moved, iter, best, pick, d, ct, nv;
    int unsigned sums [8][4];
    int unsigned cnt [8];
    bit go;
    result_t r;
    nc = cfg_nc < 1 ? 1 : (cfg_nc > 8 ? 8 : cfg_nc);
    nd = cfg_nd < 1 ? 1 : (cfg_nd > 4 ? 4 : cfg_nd);
    if (npts < kmce_pkg::POINTS_PER_CLUSTER * nc) begin
      r = '0; r.status = 1'b1; r.last = 1'b1;
      expected_results.push_back(r);
      return;
    end
    step = npts / nc;
    for (int n = 0; n < nc; n++) begin
      lo = n * step; hi = (n + 1) * step;
      if (n == nc - 1) hi = npts;
      if (hi <= lo) hi = lo + 1;
      for (int i = 0; i < nd; i++) begin
        acc = 0;
        for (int k = lo; k < hi && k < NPTS; k++) acc += pts[k][i];
        ctr[n][i] = acc / (hi - lo);
      end
    end
    iter = 0;
    lim = nc * nd * cfg_thr;
    go = 1;
    while (go) begin
      foreach (cnt[k]) begin
        cnt[k] = 0;
        for (int i = 0; i < 4; i++) sums[k][i] = 0;
      end
      for (int n = 0; n < npts; n++) begin
        best = 1000000000; pick = 0;
        for (int k = 0; k < nc; k++) begin
          d = 0;
          for (int i = 0; i < nd; i++) d += adiff(pts[n][i], ctr[k][i]) ** 2;
          if (d < best) begin
            best = d; pick = k;
          end
        end
        lbl[n] = 3'(pick); lbl_ok[n] = 1;
        for (int i = 0; i < nd; i++) sums[pick][i] += pts[n][i];
        cnt[pick]++;
      end
      moved = 0;
      for (int k = 0; k < nc; k++) begin
        ct = cnt[k];
        for (int i = 0; i < nd; i++) begin
          nv = ct > kmce_pkg::MIN_MEMBERS ? sums[k][i] / ct : ctr[k][i];
          moved += adiff(ctr[k][i], nv);
          ctr[k][i] = nv;
        end
      end
      if (iter > kmce_pkg::ITER_LIMIT || moved < lim) go = 0;
      iter++;
    end
    for (int k = 0; k < nc; k++) begin
      r = '0;
      r.cluster_index = 3'(k);
      r.percent = 7'((kmce_pkg::PERCENT_SCALE * cnt[k]) / npts);
      r.center_0 = 8'(ctr[k][0]);
      r.center_1 = nd > 1 ? 8'(ctr[k][1]) : 8'd0;
      r.center_2 = nd > 2 ? 8'(ctr[k][2]) : 8'd0;
      r.center_3 = nd > 3 ? 8'(ctr[k][3]) : 8'd0;
      r.last = (k == nc - 1);
      expected_results.push_back(r);
    end
  endtask

  task automatic predict(input item_t it);
    result_t r;
    case (it.act)
      kmce_pkg::ACT_LOAD: if (npts < NPTS) begin
        pts[npts][0] = it.c0; pts[npts][1] = it.c1;
        pts[npts][2] = it.c2; pts[npts][3] = it.c3;
        npts++;
      end
      kmce_pkg::ACT_CLEAR: npts = 0;
      kmce_pkg::ACT_READ: begin
        r = '0; r.kind = 1'b1; r.last = 1'b1; r.label = lbl[it.idx];
        expected_results.push_back(r);
      end
      default: cluster_points();
    endcase
  endtask

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #50000000;
    $display("Some tests failed");
    $finish;
  end

  task automatic write_reg(input kmce_pkg::reg_idx_e ri, input int unsigned v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {ri, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
    case (ri)
      kmce_pkg::REG_NUM_CLUSTERS: cfg_nc = v & 4'hf;
      kmce_pkg::REG_NUM_DIMS:     cfg_nd = v & 3'h7;
      default:                    cfg_thr = v & 8'hff;
    endcase
  endtask

  // valid stays up between back-to-back items and drops only while idling
  task automatic send(input item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    action_i <= it.act;
    coord_0_i <= it.c0; coord_1_i <= it.c1; coord_2_i <= it.c2; coord_3_i <= it.c3;
    point_index_i <= it.idx;
    do @(posedge clk_i); while (!in_ready_o);
    predict(it);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid_i <= 0;
    while (expected_results.size() != 0 && guard < 2000000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  // checker
  always @(posedge clk_i) begin
    result_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        w = expected_results.pop_front();
        if (kind_o !== w.kind) report("kind", kind_o, w.kind);
        if (status_o !== w.status) report("status", status_o, w.status);
        if (cluster_index_o !== w.cluster_index)
          report("cluster_index", cluster_index_o, w.cluster_index);
        if (percent_o !== w.percent) report("percent", percent_o, w.percent);
        if (center_0_o !== w.center_0) report("center_0", center_0_o, w.center_0);
        if (center_1_o !== w.center_1) report("center_1", center_1_o, w.center_1);
        if (center_2_o !== w.center_2) report("center_2", center_2_o, w.center_2);
        if (center_3_o !== w.center_3) report("center_3", center_3_o, w.center_3);
        if (label_o !== w.label) report("label", label_o, w.label);
        if (last_o !== w.last) report("last", last_o, w.last);
      end
    end
  end

  always @(posedge clk_i) out_ready_i <= $urandom_range(99) >= recv_idle;

  function automatic item_t mk(kmce_pkg::action_e a, int c0 = 0, int c1 = 0, int c2 = 0,
                               int c3 = 0, int ix = 0);
    item_t it;
    it.act = a; it.c0 = 8'(c0); it.c1 = 8'(c1); it.c2 = 8'(c2); it.c3 = 8'(c3);
    it.idx = 10'(ix);
    return it;
  endfunction

  function automatic item_t rnd_point();
    return mk(kmce_pkg::ACT_LOAD, $urandom_range(255), $urandom_range(255),
              $urandom_range(255), $urandom_range(255));
  endfunction

  item_t directed [$];
  int nitems;

  initial begin
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid_i = 0; action_i = kmce_pkg::ACT_LOAD; coord_0_i = 0; coord_1_i = 0;
    coord_2_i = 0; coord_3_i = 0; point_index_i = 0;
    errors = 0; npts = 0; send_idle = 0; recv_idle = 0;
    cfg_nc = kmce_pkg::NC_RESET; cfg_nd = kmce_pkg::ND_RESET; cfg_thr = kmce_pkg::THR_RESET;
    foreach (lbl[i]) begin
      lbl[i] = 0; lbl_ok[i] = 0;
    end
    rst_ni = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: run with no points is an error, then extremes
    directed.push_back(mk(kmce_pkg::ACT_RUN));
    for (int i = 0; i < 12; i++)
      directed.push_back(i % 2 ? mk(kmce_pkg::ACT_LOAD, 255, 255, 255, 255)
                               : mk(kmce_pkg::ACT_LOAD, 0, 0, 0, 0));
    directed.push_back(mk(kmce_pkg::ACT_RUN));
    directed.push_back(mk(kmce_pkg::ACT_READ, 0, 0, 0, 0, 0));
    directed.push_back(mk(kmce_pkg::ACT_READ, 0, 0, 0, 0, 11));
    directed.push_back(mk(kmce_pkg::ACT_CLEAR));
    directed.push_back(mk(kmce_pkg::ACT_RUN));
    foreach (directed[i]) begin
      send(directed[i]);
      // the two error runs can be read off directly
      if (directed[i].act == kmce_pkg::ACT_RUN && npts == 0) begin
        result_t r;
        r = '0; r.status = 1'b1; r.last = 1'b1;
        if (expected_results[$] !== r) report("error row", 0, 1);
      end
    end
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      int nc, nd;
      send_idle = ph < 2 ? 21 : (ph < 4 ? 51 : 0);
      recv_idle = ph < 2 ? 51 : (ph < 4 ? 21 : 0);
      nc = (ph == 0) ? 8 : (ph == 1 ? 1 : $urandom_range(0, 15));
      nd = (ph == 2) ? 4 : (ph == 3 ? 1 : $urandom_range(0, 7));
      write_reg(kmce_pkg::REG_NUM_CLUSTERS, nc);
      write_reg(kmce_pkg::REG_NUM_DIMS, nd);
      write_reg(kmce_pkg::REG_ERR_THR, ph == 4 ? 0 : (ph == 5 ? 255 : $urandom_range(255)));
      nitems = 0;
      while (nitems < 28) begin
        int n;
        n = $urandom_range(4, 40);
        if ($urandom_range(9) == 0) n = $urandom_range(0, 6);
        send(mk(kmce_pkg::ACT_CLEAR));
        for (int i = 0; i < n; i++) send(rnd_point());
        send(mk(kmce_pkg::ACT_RUN));
        nitems += n + 2;
        repeat ($urandom_range(1, 4)) begin
          int ix;
          ix = $urandom_range(1023);
          if (!lbl_ok[ix]) ix = 0;
          if (lbl_ok[ix]) begin
            send(mk(kmce_pkg::ACT_READ, 0, 0, 0, 0, ix));
            nitems++;
          end
        end
      end
      wait_idle();
    end

    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/kmce_pkg.sv
hw/rtl/kmce_div.sv
hw/rtl/kmce_lane.sv
hw/rtl/kmce_merge.sv
hw/rtl/kmeans_clustering_engine.sv
bench/tb.sv
